FILE: rtl/core/lts_pkg.sv
package lts_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   localparam logic [7:0] QUANTUM_RESET = 8'd10;

   // Input opcodes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_YIELD = 2'd1;
   localparam logic [1:0] OP_SPAWN = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_ENABLE  = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic       exited;
   } req_type;

   typedef struct packed {
      logic        switched;
      logic [15:0] running_pid;
      logic [15:0] spawned_pid;
      logic [4:0]  task_count;
      logic [1:0]  status;
   } rsp_type;

   // One write to the task table; the two fields have separate enables.
   typedef struct packed {
      logic             pid_we;
      logic             lr_we;
      logic [IDX_W-1:0] addr;
      logic [15:0]      pid;
      logic [31:0]      last_run;
   } wr_type;

   // Control of the distance compare unit.
   typedef struct packed {
      logic             clear;
      logic             step;
      logic [IDX_W-1:0] idx;
   } dist_ctl_type;

endpackage

FILE: rtl/core/lru_time_slice_scheduler_top.sv
// Channel   Direction  Word                          Flow control
// req_      in         opcode, exited                req_valid / req_stall
// rsp_      out        switched, running_pid,        rsp_valid / rsp_stall
//                      spawned_pid, task_count, status
// csr_      in         enable (0), quantum (1)       csr_wr_en, no wait
//
// Spawns, disabled ticks and plain slice countdowns finish in the accept cycle.
// A switch passes ST_SWITCH, walks the table once in ST_SCAN through the distance
// compare unit and stamps the pick in ST_STAMP. An exit first walks the table in
// ST_FIND and ST_SHIFT to find and remove the task. No new word is taken meanwhile.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A result waits in the output register under rsp_stall, and the next word is
// accepted in the cycle that result leaves.
module lru_time_slice_scheduler_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lts_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lts_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [7:0]       csr_wr_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FIND   = 6'b000010,
      ST_SHIFT  = 6'b000100,
      ST_SWITCH = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_STAMP  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [lts_pkg::CNT_W-1:0]   idx_ff, idx_in, idx_nx;
   logic [lts_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [15:0]                 current_pid_ff, current_pid_in;
   logic [7:0]                  slice_ff, slice_in, slice_eff;
   logic [31:0]                 tick_ff, tick_in;
   logic [15:0]                 pid_ctr_ff, pid_ctr_in;
   logic                        enable_ff;
   logic [7:0]                  quantum_ff;
   lts_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        accept;
   logic                        load;
   logic                        switched;
   logic [15:0]                 spawned;
   logic [1:0]                  status;

   lts_pkg::wr_type             wr;
   logic [lts_pkg::IDX_W-1:0]   rd_addr;
   logic [15:0]                 rd_pid;
   logic [31:0]                 rd_last_run;
   lts_pkg::dist_ctl_type       dctl;
   logic [lts_pkg::IDX_W-1:0]   pick;

   lts_table u_table (
      .clock       (clock),
      .wr          (wr),
      .rd_addr     (rd_addr),
      .rd_pid      (rd_pid),
      .rd_last_run (rd_last_run)
   );

   lts_dist u_dist (
      .clock    (clock),
      .ctl      (dctl),
      .last_run (rd_last_run),
      .tick_now (tick_ff),
      .pick     (pick)
   );

   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign idx_nx    = idx_ff + lts_pkg::CNT_W'(1);
   assign slice_eff = (req_word.opcode == lts_pkg::OP_YIELD) ? 8'd0 : slice_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      current_pid_in = current_pid_ff;
      slice_in       = slice_ff;
      tick_in        = tick_ff;
      pid_ctr_in     = pid_ctr_ff;
      wr             = '0;
      rd_addr        = idx_ff[lts_pkg::IDX_W-1:0];
      dctl           = '0;
      dctl.idx       = idx_ff[lts_pkg::IDX_W-1:0];
      load           = 1'b0;
      switched       = 1'b0;
      spawned        = 16'd0;
      status         = lts_pkg::STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_word.opcode)
                  lts_pkg::OP_SPAWN: begin
                     load = 1'b1;
                     if (count_ff >= lts_pkg::CNT_W'(lts_pkg::MAX_TASKS)) begin
                        status = lts_pkg::STATUS_FULL;
                     end else begin
                        wr.pid_we   = 1'b1;
                        wr.lr_we    = 1'b1;
                        wr.addr     = count_ff[lts_pkg::IDX_W-1:0];
                        wr.pid      = pid_ctr_ff;
                        wr.last_run = 32'd0;
                        count_in    = count_ff + lts_pkg::CNT_W'(1);
                        pid_ctr_in  = pid_ctr_ff + 16'd1;
                        spawned     = pid_ctr_ff;
                     end
                  end
                  lts_pkg::OP_TICK, lts_pkg::OP_YIELD: begin
                     slice_in = slice_eff;
                     if (!enable_ff) begin
                        load = 1'b1;
                     end else if (req_word.exited) begin
                        idx_in   = '0;
                        state_in = ST_FIND;
                     end else if (slice_eff == 8'd0) begin
                        state_in = ST_SWITCH;
                     end else begin
                        slice_in = slice_eff - 8'd1;
                        tick_in  = tick_ff + 32'd1;
                        load     = 1'b1;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_FIND: begin
            // A task that is not in the table is simply not removed.
            if (idx_ff == count_ff) begin
               state_in = ST_SWITCH;
            end else if (rd_pid == current_pid_ff) begin
               state_in = ST_SHIFT;
            end else begin
               idx_in = idx_nx;
            end
         end
         ST_SHIFT: begin
            if (idx_nx < count_ff) begin
               rd_addr     = idx_nx[lts_pkg::IDX_W-1:0];
               wr.pid_we   = 1'b1;
               wr.lr_we    = 1'b1;
               wr.addr     = idx_ff[lts_pkg::IDX_W-1:0];
               wr.pid      = rd_pid;
               wr.last_run = rd_last_run;
               idx_in      = idx_nx;
            end else begin
               count_in = count_ff - lts_pkg::CNT_W'(1);
               state_in = ST_SWITCH;
            end
         end
         ST_SWITCH: begin
            if (count_ff == '0) begin
               status   = lts_pkg::STATUS_EMPTY;
               tick_in  = tick_ff + 32'd1;
               load     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               dctl.clear = 1'b1;
               idx_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = ST_STAMP;
            end else begin
               dctl.step = 1'b1;
               idx_in    = idx_nx;
            end
         end
         ST_STAMP: begin
            rd_addr        = pick;
            wr.lr_we       = 1'b1;
            wr.addr        = pick;
            wr.last_run    = tick_ff;
            current_pid_in = rd_pid;
            slice_in       = quantum_ff;
            tick_in        = tick_ff + 32'd1;
            switched       = 1'b1;
            load           = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_in.switched    = switched;
         rsp_in.running_pid = current_pid_in;
         rsp_in.spawned_pid = spawned;
         rsp_in.task_count  = 5'(count_in);
         rsp_in.status      = status;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         count_ff       <= '0;
         current_pid_ff <= 16'd0;
         slice_ff       <= 8'd0;
         tick_ff        <= 32'd0;
         pid_ctr_ff     <= 16'd0;
         enable_ff      <= 1'b0;
         quantum_ff     <= lts_pkg::QUANTUM_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         count_ff       <= count_in;
         current_pid_ff <= current_pid_in;
         slice_ff       <= slice_in;
         tick_ff        <= tick_in;
         pid_ctr_ff     <= pid_ctr_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               lts_pkg::CSR_ENABLE:  enable_ff  <= csr_wr_data[0];
               lts_pkg::CSR_QUANTUM: quantum_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lts_pkg::CNT_W'(lts_pkg::MAX_TASKS))
      else $error("task count above table size");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input taken while a word is in progress");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND || state_ff == ST_SCAN || state_ff == ST_SHIFT)
      |-> idx_ff <= count_ff)
      else $error("table walk past the last entry");

   a_stamp_reload: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STAMP |=> slice_ff == $past(quantum_ff) && rsp_valid_ff
      && rsp_word.switched)
      else $error("switch did not reload the slice or report");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> count_ff != '0)
      else $error("selection walk over an empty table");

endmodule

FILE: rtl/core/lts_table.sv
module lts_table (
   input  logic                         clock,
   input  lts_pkg::wr_type              wr,
   input  logic [lts_pkg::IDX_W-1:0]    rd_addr,
   output logic [15:0]                  rd_pid,
   output logic [31:0]                  rd_last_run
);

   logic [15:0] pid_ff      [lts_pkg::MAX_TASKS];
   logic [31:0] last_run_ff [lts_pkg::MAX_TASKS];

   always_ff @(posedge clock) begin
      if (wr.pid_we) begin
         pid_ff[wr.addr] <= wr.pid;
      end
      if (wr.lr_we) begin
         last_run_ff[wr.addr] <= wr.last_run;
      end
   end

   // Single read port, used by one sequencer step at a time.
   assign rd_pid      = pid_ff[rd_addr];
   assign rd_last_run = last_run_ff[rd_addr];

endmodule

FILE: rtl/core/lts_dist.sv
module lts_dist (
   input  logic                         clock,
   input  lts_pkg::dist_ctl_type        ctl,
   input  logic [31:0]                  last_run,
   input  logic [31:0]                  tick_now,
   output logic [lts_pkg::IDX_W-1:0]    pick
);

   logic [31:0]               best_ff;
   logic [31:0]               best_in;
   logic [lts_pkg::IDX_W-1:0] pick_ff;
   logic [lts_pkg::IDX_W-1:0] pick_in;
   logic [31:0]               span;

   assign span = (last_run > tick_now) ? (last_run - tick_now) : (tick_now - last_run);

   // Only a strictly greater distance replaces the pick, so ties keep the first entry.
   always_comb begin
      best_in = best_ff;
      pick_in = pick_ff;
      if (ctl.clear) begin
         best_in = '0;
         pick_in = '0;
      end else if (ctl.step && (span > best_ff)) begin
         best_in = span;
         pick_in = ctl.idx;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      pick_ff <= pick_in;
   end

   assign pick = pick_ff;

endmodule
